// File: rtl/hcm26_pkg.sv
// ----------------------------------------------------------------------------
// hcm26_pkg
// Shared types, constants and mod-26 helpers for the Hill cipher block.
// ----------------------------------------------------------------------------
package hcm26_pkg;

    localparam int unsigned LETTER_W = 5;
    localparam int unsigned KEY_W    = 45;
    localparam int unsigned PROD_W   = 10;
    localparam int unsigned SUM_W    = 11;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [LETTER_W-1:0] ALPHA      = 5'd26;
    localparam logic [SUM_W-1:0]    ALPHA_SQ   = 11'd676;
    localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd23;   // 'x'

    // cycles from a config write until the derived key is usable
    localparam logic [2:0] SETTLE_CYCLES = 3'd5;

    typedef logic [LETTER_W-1:0] t_letter;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_MATRIX   = 2'd0,
        CFG_KEY_ORDER    = 2'd1,
        CFG_DECRYPT_MODE = 2'd2
    } t_cfg_idx;

    // effective key handed from key prep to the datapath
    typedef struct packed {
        logic                      busy;
        logic                      key_err;
        logic [8:0][LETTER_W-1:0]  m;        // entry (r,c) at index 3r+c
    } t_key_info;

    // 0..31 -> 0..25
    function automatic t_letter red_letter(input logic [LETTER_W-1:0] x);
        red_letter = (x >= ALPHA) ? x - ALPHA : x;
    endfunction

    // 0..2047 -> 0..25, reciprocal multiply (315/8192 just under 1/26) plus one fixup
    function automatic t_letter mod_alpha(input logic [SUM_W-1:0] x);
        logic [19:0]      prod;
        logic [6:0]       q;
        logic [SUM_W-1:0] r;
        prod = {9'd0, x} * 20'd315;
        q    = prod[19:13];
        r    = x - ({4'd0, q} * {6'd0, ALPHA});
        if (r >= {6'd0, ALPHA}) begin
            r = r - {6'd0, ALPHA};
        end
        mod_alpha = r[LETTER_W-1:0];
    endfunction

    // (26 - k) mod 26
    function automatic t_letter neg_alpha(input t_letter k);
        neg_alpha = (k == 5'd0) ? 5'd0 : ALPHA - k;
    endfunction

    // multiplicative inverse mod 26, 0 when none exists
    function automatic t_letter inv_alpha(input t_letter d);
        case (d)
            5'd1:    inv_alpha = 5'd1;
            5'd3:    inv_alpha = 5'd9;
            5'd5:    inv_alpha = 5'd21;
            5'd7:    inv_alpha = 5'd15;
            5'd9:    inv_alpha = 5'd3;
            5'd11:   inv_alpha = 5'd19;
            5'd15:   inv_alpha = 5'd7;
            5'd17:   inv_alpha = 5'd23;
            5'd19:   inv_alpha = 5'd11;
            5'd21:   inv_alpha = 5'd5;
            5'd23:   inv_alpha = 5'd17;
            5'd25:   inv_alpha = 5'd25;
            default: inv_alpha = 5'd0;
        endcase
    endfunction

endpackage

// File: rtl/hcm26_key_prep.sv
// ----------------------------------------------------------------------------
// hcm26_key_prep
// Derives the effective key (K or its 2x2 inverse mod 26) from the config
// registers through a short pipeline; flags busy until it has settled.
// ----------------------------------------------------------------------------
module hcm26_key_prep (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [hcm26_pkg::KEY_W-1:0]    i_key,
    input  logic                           i_order3,
    input  logic                           i_dec,
    input  logic                           i_cfg_wr,
    output hcm26_pkg::t_key_info           o_key
);

    hcm26_pkg::t_letter                       r_k [9];
    logic [hcm26_pkg::PROD_W-1:0]             r_p;
    logic [hcm26_pkg::PROD_W-1:0]             r_q;
    hcm26_pkg::t_letter                       r_det;
    logic [hcm26_pkg::PROD_W-1:0]             r_a [4];
    logic                                     r_dinv_zero;
    logic [8:0][hcm26_pkg::LETTER_W-1:0]      r_m;
    logic                                     r_key_err;
    logic [2:0]                               r_settle;

    hcm26_pkg::t_letter                       dinv;
    logic [8:0][hcm26_pkg::LETTER_W-1:0]      n_m;

    assign dinv = hcm26_pkg::inv_alpha(r_det);

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            n_m[i] = r_k[i];
        end
        if (i_dec) begin
            n_m[0] = hcm26_pkg::mod_alpha({1'b0, r_a[0]});
            n_m[1] = hcm26_pkg::mod_alpha({1'b0, r_a[1]});
            n_m[3] = hcm26_pkg::mod_alpha({1'b0, r_a[2]});
            n_m[4] = hcm26_pkg::mod_alpha({1'b0, r_a[3]});
        end
    end

    always_ff @(posedge i_clk) begin
        // stage 1: entries reduced mod 26
        for (int i = 0; i < 9; i++) begin
            r_k[i] <= hcm26_pkg::red_letter(i_key[5*i +: 5]);
        end
        // stage 2: determinant products
        r_p <= r_k[0] * r_k[4];
        r_q <= r_k[1] * r_k[3];
        // stage 3: determinant mod 26, kept non-negative
        r_det <= hcm26_pkg::mod_alpha({1'b0, r_p} + hcm26_pkg::ALPHA_SQ - {1'b0, r_q});
        // stage 4: adjugate times inverse determinant
        r_a[0]      <= r_k[4] * dinv;
        r_a[1]      <= hcm26_pkg::neg_alpha(r_k[1]) * dinv;
        r_a[2]      <= hcm26_pkg::neg_alpha(r_k[3]) * dinv;
        r_a[3]      <= r_k[0] * dinv;
        r_dinv_zero <= (dinv == 5'd0);
        // stage 5: final key
        r_m       <= n_m;
        r_key_err <= i_dec && (i_order3 || r_dinv_zero);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= hcm26_pkg::SETTLE_CYCLES;
        end else if (i_cfg_wr) begin
            r_settle <= hcm26_pkg::SETTLE_CYCLES;
        end else if (r_settle != 3'd0) begin
            r_settle <= r_settle - 3'd1;
        end
    end

    assign o_key.busy    = (r_settle != 3'd0);
    assign o_key.key_err = r_key_err;
    assign o_key.m       = r_m;

endmodule

// File: rtl/hill_cipher_mod26_top.sv
// ----------------------------------------------------------------------------
// hill_cipher_mod26_top
// Hill cipher over a 26-letter alphabet, one letter per item.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) takes one letter per item plus a
// final-letter mark. Letters are gathered into blocks of 2 or 3 (key_order);
// a finished block is multiplied by the key (or its 2x2 inverse in decrypt
// mode) mod 26 and its letters are held in a small output buffer.
// Buffered letters leave one per accepted input item, on the output channel
// (o_out_valid / i_out_stall), the result register loading on the edge that
// takes that item. So a block's letters come out on the items that follow
// the one that finished it; the last block of a message needs further items.
// Throughput: one item per cycle while o_in_stall is low. A result is valid in
// the cycle after the item that pulls it. Apart from key settling, o_in_stall
// rises only when a result is pending and the result register is full and
// stalled by the receiver. Config (i_cfg_valid / o_cfg_ready) is always ready;
// after any write, and after reset, input stalls while the key pipeline settles.
// Writing key_order or decrypt_mode drops a partly filled input block.
// Decrypt with order 3 or a singular key yields one result with key_error.
// ----------------------------------------------------------------------------
module hill_cipher_mod26_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input items
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [hcm26_pkg::LETTER_W-1:0]     i_letter_in,
    input  logic                               i_final_letter,
    // result items
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [hcm26_pkg::LETTER_W-1:0]     o_letter_out,
    output logic                               o_block_last,
    output logic                               o_key_error,
    // config writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [hcm26_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hcm26_pkg::KEY_W-1:0]        i_cfg_data
);

    // config
    logic [hcm26_pkg::KEY_W-1:0]      r_key;
    logic [1:0]                       r_order;
    logic                             r_dec;

    // block and output buffer
    hcm26_pkg::t_letter               r_blk [3];
    logic [1:0]                       r_fill;
    logic [1:0]                       r_emit;
    logic [1:0]                       r_olen;
    logic                             r_oerr;
    logic [hcm26_pkg::SUM_W-1:0]      r_osum [3];

    // result register
    logic                             r_out_valid;
    hcm26_pkg::t_letter               r_out_letter;
    logic                             r_out_last;
    logic                             r_out_err;

    hcm26_pkg::t_key_info             key;

    logic                             cfg_wr;
    logic                             in_acc;
    logic                             pend;
    logic                             order3;
    logic [1:0]                       f;
    logic [1:0]                       f1;
    logic                             full;
    logic                             fin;
    hcm26_pkg::t_letter               letter;
    hcm26_pkg::t_letter               b [3];
    logic [hcm26_pkg::SUM_W-1:0]      col [3];
    logic [hcm26_pkg::SUM_W-1:0]      emit_sum;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_order <= 2'd2;
            r_dec   <= 1'b0;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                hcm26_pkg::CFG_KEY_MATRIX:   r_key   <= i_cfg_data;
                hcm26_pkg::CFG_KEY_ORDER:    r_order <= i_cfg_data[1:0];
                hcm26_pkg::CFG_DECRYPT_MODE: r_dec   <= i_cfg_data[0];
                default:                     r_key   <= r_key;
            endcase
        end
    end

    assign order3 = (r_order == 2'd3);

    hcm26_key_prep u_key_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key    (r_key),
        .i_order3 (order3),
        .i_dec    (r_dec),
        .i_cfg_wr (cfg_wr),
        .o_key    (key)
    );

    assign pend       = (r_emit < r_olen);
    assign o_in_stall = key.busy || (pend && r_out_valid && i_out_stall);
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        letter = hcm26_pkg::red_letter(i_letter_in);
        f      = (r_fill >= (order3 ? 2'd3 : 2'd2)) ? 2'd0 : r_fill;
        f1     = f + 2'd1;
        full   = (f1 >= (order3 ? 2'd3 : 2'd2));
        fin    = full || (i_final_letter && !r_dec);
        // block as it stands after this letter, padded with 'x'
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < f) begin
                b[i] = r_blk[i];
            end else if (2'(i) == f) begin
                b[i] = letter;
            end else begin
                b[i] = hcm26_pkg::PAD_LETTER;
            end
        end
        // products kept at full 10-bit width
        for (int c = 0; c < 3; c++) begin
            col[c] = {1'b0, {5'd0, b[0]} * {5'd0, key.m[c]}}
                   + {1'b0, {5'd0, b[1]} * {5'd0, key.m[3 + c]}}
                   + (order3 ? {1'b0, {5'd0, b[2]} * {5'd0, key.m[6 + c]}} : '0);
        end
        case (r_emit)
            2'd0:    emit_sum = r_osum[0];
            2'd1:    emit_sum = r_osum[1];
            default: emit_sum = r_osum[2];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= 2'd0;
            r_emit      <= 2'd0;
            r_olen      <= 2'd0;
            r_oerr      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc && pend) begin
                r_out_valid  <= 1'b1;
                r_out_letter <= hcm26_pkg::mod_alpha(emit_sum);
                r_out_last   <= (r_emit + 2'd1 == r_olen);
                r_out_err    <= r_oerr;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end

            if (cfg_wr && (i_cfg_index == hcm26_pkg::CFG_KEY_ORDER ||
                           i_cfg_index == hcm26_pkg::CFG_DECRYPT_MODE)) begin
                r_fill <= 2'd0;
            end else if (in_acc) begin
                if (fin) begin
                    r_fill <= 2'd0;
                    r_emit <= 2'd0;
                    if (key.key_err) begin
                        r_olen    <= 2'd1;
                        r_oerr    <= 1'b1;
                        r_osum[0] <= '0;
                    end else begin
                        r_olen <= order3 ? 2'd3 : 2'd2;
                        r_oerr <= 1'b0;
                        for (int c = 0; c < 3; c++) begin
                            r_osum[c] <= col[c];
                        end
                    end
                end else begin
                    if (pend) begin
                        r_emit <= r_emit + 2'd1;
                    end
                    if (i_final_letter) begin
                        // decrypt drops a partial final block
                        r_fill <= 2'd0;
                    end else begin
                        r_blk[f] <= letter;
                        r_fill   <= f1;
                    end
                end
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_letter_out = r_out_letter;
    assign o_block_last = r_out_last;
    assign o_key_error  = r_out_err;

    // buffer read pointer never passes the buffer length
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit <= r_olen)
        else $error("emit pointer past buffered block");

    // fill count stays below three letters
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill != 2'd3)
        else $error("block fill count out of range");

    // an error result is a one-letter block of letter a
    a_err_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_key_error) |-> (o_block_last && o_letter_out == 5'd0))
        else $error("key error result malformed");

endmodule
